[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define LCAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define LCAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also covers reset itself.
`define LCAT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

[hdl/lcat_pkg.sv]
`timescale 1ns / 1ps
package lcat_pkg;

    localparam int RAW_W       = 24;
    localparam int LIMIT_W     = 15;
    localparam int SCALE_W     = 32;
    localparam int WEIGHT_W    = 32;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int SAMPLES_DEF = 20;

    localparam logic [RAW_W-1:0]   SIGN_FLIP   = 24'h80_0000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd2006994;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b1;

    typedef logic [WEIGHT_W-1:0] t_weight;

endpackage

[hdl/lcat_in_if.sv]
`timescale 1ns / 1ps
interface lcat_in_if import lcat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_word;
    logic             zero_request;

    modport source (output valid, raw_word, zero_request, input ready);
    modport sink   (input valid, raw_word, zero_request, output ready);
endinterface

[hdl/lcat_out_if.sv]
`timescale 1ns / 1ps
interface lcat_out_if import lcat_pkg::*; ();
    logic    valid;
    logic    ready;
    t_weight weight_q16;
    logic    over_limit;

    modport source (output valid, weight_q16, over_limit, input ready);
    modport sink   (input valid, weight_q16, over_limit, output ready);
endinterface

[hdl/load_cell_average_tare_threshold.sv]
`timescale 1ns / 1ps
// Throughput: one input word per cycle unless stalled; the window sum is updated as each word is taken.
// Pipeline: after its last word is taken, the result of a window passes through a
//   six-register pipeline (tare-difference register, two divide-by-constant stages,
//   two product stages, output register); each stage stalls only when full and blocked.
// Reset (synchronous, active low) clears the window, the tare, the pipeline valids and
//   sets limit to 0 and scale to 2006994; no clearing pass.
module load_cell_average_tare_threshold import lcat_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lcat_in_if.sink               i_sample,
    lcat_out_if.source            o_result
);

    localparam int L_SH   = $clog2(SAMPLES);
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int DIFF_W = RAW_W + L_SH;
    localparam int RR_W   = 2 * CNT_W;
    localparam int P2_W   = SCALE_W + CNT_W;
    localparam int PROD_W = DIFF_W + SCALE_W;

    // Reciprocals for exact floor division by SAMPLES
    localparam int K1 = DIFF_W + L_SH;
    localparam int K2 = SCALE_W + L_SH;
    localparam int K3 = RR_W + L_SH;
    localparam longint unsigned M1_L = ((64'd1 << K1) + SAMPLES - 1) / SAMPLES;
    localparam longint unsigned M2_L = ((64'd1 << K2) + SAMPLES - 1) / SAMPLES;
    localparam longint unsigned M3_L = ((64'd1 << K3) + SAMPLES - 1) / SAMPLES;
    localparam logic [DIFF_W:0]  M1 = (DIFF_W + 1)'(M1_L);
    localparam logic [SCALE_W:0] M2 = (SCALE_W + 1)'(M2_L);
    localparam logic [RR_W:0]    M3 = (RR_W + 1)'(M3_L);

    // Configuration
    logic [LIMIT_W-1:0] r_limit;
    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Window and tare state
    logic [DIFF_W-1:0] r_window_sum, n_window_sum;
    logic [CNT_W-1:0]  r_window_count, n_window_count;
    logic [DIFF_W-1:0] r_tare_sum, n_tare_sum;
    logic              r_tare_valid, n_tare_valid;
    logic              r_tare_pending, n_tare_pending;

    logic w_accept, w_closing, w_pending, w_take_tare, w_emit;
    logic [RAW_W-1:0]  w_count;
    logic [DIFF_W-1:0] w_sum, w_diff;

    // Pipeline valids and advance chain
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    logic w_adv1, w_adv2, w_adv3, w_adv4, w_adv5, w_adv_out;

    assign w_adv_out = !r_out_v || o_result.ready;
    assign w_adv5    = !r_s5_v  || w_adv_out;
    assign w_adv4    = !r_s4_v  || w_adv5;
    assign w_adv3    = !r_s3_v  || w_adv4;
    assign w_adv2    = !r_s2_v  || w_adv3;
    assign w_adv1    = !r_s1_v  || w_adv2;

    assign i_sample.ready = w_adv1;
    assign w_accept       = i_sample.valid && w_adv1;

    assign w_count     = i_sample.raw_word ^ SIGN_FLIP;
    assign w_sum       = r_window_sum + DIFF_W'(w_count);
    assign w_closing   = (r_window_count == CNT_W'(SAMPLES - 1));
    assign w_pending   = r_tare_pending || i_sample.zero_request;
    assign w_take_tare = !r_tare_valid || w_pending;
    assign w_emit      = w_accept && w_closing && !w_take_tare;
    assign w_diff      = (w_sum >= r_tare_sum) ? (w_sum - r_tare_sum) : (r_tare_sum - w_sum);

    always_comb begin
        n_window_sum   = r_window_sum;
        n_window_count = r_window_count;
        n_tare_sum     = r_tare_sum;
        n_tare_valid   = r_tare_valid;
        n_tare_pending = r_tare_pending;
        if (w_accept) begin
            if (w_closing) begin
                n_window_sum   = '0;
                n_window_count = '0;
                if (w_take_tare) begin
                    n_tare_sum     = w_sum;
                    n_tare_valid   = 1'b1;
                    n_tare_pending = 1'b0;
                end
            end else begin
                n_window_sum   = w_sum;
                n_window_count = r_window_count + CNT_W'(1);
                n_tare_pending = w_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_sum   <= '0;
            r_window_count <= '0;
            r_tare_sum     <= '0;
            r_tare_valid   <= 1'b0;
            r_tare_pending <= 1'b0;
        end else begin
            r_window_sum   <= n_window_sum;
            r_window_count <= n_window_count;
            r_tare_sum     <= n_tare_sum;
            r_tare_valid   <= n_tare_valid;
            r_tare_pending <= n_tare_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv1)    r_s1_v  <= w_emit;
            if (w_adv2)    r_s2_v  <= r_s1_v;
            if (w_adv3)    r_s3_v  <= r_s2_v;
            if (w_adv4)    r_s4_v  <= r_s3_v;
            if (w_adv5)    r_s5_v  <= r_s4_v;
            if (w_adv_out) r_out_v <= r_s5_v;
        end
    end

    // Payload path.  weight = (scale*dq + sq*dr + (sr*dr)/S) >> 16, where
    // diff = dq*S + dr and scale = sq*S + sr; this equals scale*diff / (S * 2^16).
    logic [DIFF_W-1:0]  r_s1_diff;

    logic [DIFF_W-1:0]  r_s2_diff, r_s2_dq;
    logic [SCALE_W-1:0] r_s2_scale, r_s2_sq;
    logic [2*DIFF_W:0]  w_prod1;
    logic [2*SCALE_W:0] w_prod2;

    logic [PROD_W-1:0]  r_s3_p1;
    logic [SCALE_W-1:0] r_s3_sq;
    logic [CNT_W-1:0]   r_s3_dr, r_s3_sr;
    logic [DIFF_W-1:0]  w_dqs, w_dr;
    logic [SCALE_W-1:0] w_sqs, w_sr;

    logic [PROD_W-1:0]  r_s4_p1;
    logic [P2_W-1:0]    r_s4_p2;
    logic [RR_W-1:0]    r_s4_rr;

    logic [PROD_W-1:0]  r_s5_p12;
    logic [CNT_W-1:0]   r_s5_rq;
    logic [2*RR_W:0]    w_prod3;

    logic [PROD_W-1:0]  w_total;
    logic               w_sat;
    t_weight            w_weight;
    t_weight            r_out_weight;
    logic               r_out_over;

    assign w_prod1 = (2*DIFF_W + 1)'(r_s1_diff) * (2*DIFF_W + 1)'(M1);
    assign w_prod2 = (2*SCALE_W + 1)'(r_scale) * (2*SCALE_W + 1)'(M2);

    assign w_dqs = DIFF_W'(r_s2_dq * DIFF_W'(SAMPLES));
    assign w_dr  = r_s2_diff - w_dqs;
    assign w_sqs = SCALE_W'(r_s2_sq * SCALE_W'(SAMPLES));
    assign w_sr  = r_s2_scale - w_sqs;

    assign w_prod3 = (2*RR_W + 1)'(r_s4_rr) * (2*RR_W + 1)'(M3);

    assign w_total  = r_s5_p12 + PROD_W'(r_s5_rq);
    assign w_sat    = |w_total[PROD_W-1:FRAC_W+WEIGHT_W];
    assign w_weight = w_sat ? '1 : w_total[FRAC_W +: WEIGHT_W];

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_diff <= w_diff;
        end
        if (w_adv2) begin
            r_s2_diff  <= r_s1_diff;
            r_s2_dq    <= DIFF_W'(w_prod1[2*DIFF_W:K1]);
            r_s2_scale <= r_scale;
            r_s2_sq    <= SCALE_W'(w_prod2[2*SCALE_W:K2]);
        end
        if (w_adv3) begin
            r_s3_p1 <= PROD_W'(r_s2_scale) * PROD_W'(r_s2_dq);
            r_s3_sq <= r_s2_sq;
            r_s3_dr <= w_dr[CNT_W-1:0];
            r_s3_sr <= w_sr[CNT_W-1:0];
        end
        if (w_adv4) begin
            r_s4_p1 <= r_s3_p1;
            r_s4_p2 <= P2_W'(r_s3_sq) * P2_W'(r_s3_dr);
            r_s4_rr <= RR_W'(r_s3_sr) * RR_W'(r_s3_dr);
        end
        if (w_adv5) begin
            r_s5_p12 <= r_s4_p1 + PROD_W'(r_s4_p2);
            r_s5_rq  <= w_prod3[K3 +: CNT_W];
        end
        if (w_adv_out) begin
            r_out_weight <= w_weight;
            r_out_over   <= (w_weight > {1'b0, r_limit, {FRAC_W{1'b0}}});
        end
    end

    assign o_result.valid      = r_out_v;
    assign o_result.weight_q16 = r_out_weight;
    assign o_result.over_limit = r_out_over;

endmodule

[hdl/lcat_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcat_checker import lcat_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_valid,
    input logic    i_ready,
    input t_weight i_weight_q16,
    input logic    i_over_limit
);

    // a stalled result word holds
    `LCAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_weight_q16) && $stable(i_over_limit))

    // zero weight can never lie above any limit
    `LCAT_ASSERT_IMP(a_zero_not_over, i_clk, i_rst_n, i_valid && (i_weight_q16 == '0), !i_over_limit)

    // a saturated weight is above every limit
    `LCAT_ASSERT_IMP(a_sat_over, i_clk, i_rst_n, i_valid && (i_weight_q16 == '1), i_over_limit)

    // reset drops the result word
    `LCAT_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !i_valid)

endmodule

bind load_cell_average_tare_threshold lcat_checker u_lcat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_weight_q16 (o_result.weight_q16),
    .i_over_limit (o_result.over_limit)
);

[tb/lcat_scale_checker.sv]
`timescale 1ns / 1ps
module lcat_scale_checker import lcat_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lcat_in_if                    i_sample,
    lcat_out_if                   i_result,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    localparam int SUM_W     = 29;
    localparam int MAX_SHOWN = 25;

    typedef struct packed {
        t_weight weight_q16;
        logic    over_limit;
    } t_reading;

    t_reading           readings_due[$];
    logic [SUM_W-1:0]   window_total;
    int                 window_fill;
    logic [SUM_W-1:0]   tare_total;
    logic               tare_held;
    logic               zero_asked;
    logic [LIMIT_W-1:0] limit_units;
    logic [SCALE_W-1:0] scale_q32;
    int                 mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_SHOWN)
            $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_weight weigh_window(input logic [SUM_W-1:0] total);
        logic [63:0] diff;
        logic [63:0] quot;
        diff = (total >= tare_total) ? 64'(total - tare_total) : 64'(tare_total - total);
        quot = (diff * 64'(scale_q32)) / (64'(SAMPLES) << FRAC_W);
        return (quot > 64'hFFFF_FFFF) ? '1 : quot[WEIGHT_W-1:0];
    endfunction

    task automatic take_word(input logic [RAW_W-1:0] raw, input logic zero_req);
        logic [SUM_W-1:0] total;
        t_weight          w;
        if (zero_req)
            zero_asked = 1'b1;
        window_total = window_total + SUM_W'(raw ^ SIGN_FLIP);
        window_fill++;
        if (window_fill == SAMPLES) begin
            total        = window_total;
            window_total = '0;
            window_fill  = 0;
            // a closed window becomes the tare until one is held, or after a zero request
            if (!tare_held || zero_asked) begin
                tare_total = total;
                tare_held  = 1'b1;
                zero_asked = 1'b0;
            end else begin
                w = weigh_window(total);
                readings_due.push_back('{weight_q16: w,
                                         over_limit: w > (WEIGHT_W'(limit_units) << FRAC_W)});
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            readings_due.delete();
            window_total = '0;
            window_fill  = 0;
            tare_total   = '0;
            tare_held    = 1'b0;
            zero_asked   = 1'b0;
            limit_units  = '0;
            scale_q32    = SCALE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT: limit_units = i_cfg_data[LIMIT_W-1:0];
                    CFG_SCALE: scale_q32   = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            // check the outgoing word first: it can never belong to this edge's input
            if (i_result.valid && i_result.ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("unexpected result", i_result.weight_q16, '0);
                end else begin
                    want = readings_due.pop_front();
                    if (i_result.weight_q16 !== want.weight_q16)
                        report_mismatch("weight_q16", i_result.weight_q16, want.weight_q16);
                    if (i_result.over_limit !== want.over_limit)
                        report_mismatch("over_limit", 32'(i_result.over_limit),
                                        32'(want.over_limit));
                end
            end
            if (i_sample.valid && i_sample.ready)
                take_word(i_sample.raw_word, i_sample.zero_request);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= readings_due.size();
    end

endmodule

[tb/load_cell_average_tare_threshold_tb.sv]
`timescale 1ns / 1ps
module load_cell_average_tare_threshold_tb;
    import lcat_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_LATE  = 12;
    localparam int ZERO_REQ_PCT = 1;

    localparam logic [RAW_W-1:0] EXTREMES [4] = '{24'h00_0000, 24'h7F_FFFF,
                                                  24'h80_0000, 24'hFF_FFFF};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rx_hold;
    int                    rx_stall_pct;
    int                    tx_idle_pct;
    int                    words_sent;
    int                    mismatches;
    int                    outstanding;
    int                    cycle_count;

    lcat_in_if  u_in ();
    lcat_out_if u_out ();

    load_cell_average_tare_threshold u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (u_in),
        .o_result   (u_out)
    );

    lcat_scale_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_sample      (u_in),
        .i_result      (u_out),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("load_cell_average_tare_threshold test failed");
        $finish;
    end

    // result side: random stalls, plus a hard hold-off when asked
    initial begin
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            u_out.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic hold_receiver();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
    endtask

    task automatic send_word(input logic [RAW_W-1:0] raw, input logic zero_req);
        while ($urandom_range(99) < tx_idle_pct) begin
            u_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in.valid        <= 1'b1;
        u_in.raw_word     <= raw;
        u_in.zero_request <= zero_req;
        do @(posedge i_clk); while (!u_in.ready);
        words_sent++;
    endtask

    task automatic send_window(input logic [RAW_W-1:0] level, input bit zero_last,
                               input bit zero_spread);
        for (int k = 0; k < SAMPLES_DEF; k++)
            send_word(level, (zero_last && k == SAMPLES_DEF - 1) ||
                             (zero_spread && k % 4 == 1 && k < 12));
    endtask

    // drop valid, wait for every reading, then let any tare window settle
    task automatic wait_quiet();
        u_in.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_LATE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic [SCALE_W-1:0] scale);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LIMIT;
        cfg_data <= ($urandom() << LIMIT_W) | CFG_DATA_W'(lim);
        @(posedge i_clk);
        cfg_idx  <= CFG_SCALE;
        cfg_data <= scale;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int n_words, input int tx_pct, input int rx_pct,
                             input bit with_hold);
        logic [RAW_W-1:0] level;
        logic [RAW_W-1:0] raw;
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        level        = RAW_W'($urandom());
        if (with_hold)
            hold_receiver();
        for (int n = 0; n < n_words; n++) begin
            if (words_sent % SAMPLES_DEF == 0)
                level = ($urandom_range(4) == 0) ? EXTREMES[$urandom_range(3)]
                                                  : RAW_W'($urandom());
            case ($urandom_range(7))
                0:       raw = RAW_W'($urandom());
                1:       raw = EXTREMES[$urandom_range(3)];
                default: raw = level ^ RAW_W'($urandom_range(1023));
            endcase
            send_word(raw, $urandom_range(99) < ZERO_REQ_PCT);
        end
        wait_quiet();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_LIMIT;
        cfg_data          <= '0;
        u_in.valid        <= 1'b0;
        u_in.raw_word     <= '0;
        u_in.zero_request <= 1'b0;
        rx_hold           <= 1'b0;
        rx_stall_pct      <= 0;
        tx_idle_pct       = 0;
        words_sent        = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first window after reset is the tare, built from the extreme words
        for (int k = 0; k < SAMPLES_DEF; k++)
            send_word(EXTREMES[k % 4], 1'b0);
        send_window(24'h80_0000, 1'b0, 1'b0);
        // zero request on the closing word, then full-scale swing against that tare
        send_window(24'h7F_FFFF, 1'b1, 1'b0);
        send_window(24'h80_0000, 1'b0, 1'b0);
        // repeated zero requests in one window act once
        send_window(24'h00_0000, 1'b0, 1'b1);
        send_window(RAW_W'($urandom()), 1'b0, 1'b0);
        wait_quiet();

        // saturation at the largest scale, then an exact match with the tare
        set_config('1, '1);
        send_window(24'h7F_FFFF, 1'b0, 1'b0);
        send_window(24'h00_0000, 1'b0, 1'b0);
        wait_quiet();
        // zero scale gives zero weight
        set_config('0, '0);
        send_window(RAW_W'($urandom()), 1'b0, 1'b0);
        wait_quiet();

        set_config(LIMIT_W'($urandom_range(8000)), SCALE_RESET);
        run_phase(200, 0, 0, 1'b1);
        set_config('1, SCALE_W'(1));
        run_phase(134, 63, 0, 1'b0);
        set_config('0, '1);
        run_phase(134, 0, 63, 1'b0);
        set_config(LIMIT_W'($urandom()), SCALE_W'($urandom()));
        run_phase(134, 23, 23, 1'b0);
        set_config(LIMIT_W'($urandom_range(100)), SCALE_W'($urandom_range(1, 1 << 22)));
        run_phase(134, 0, 0, 1'b0);
        set_config(LIMIT_W'($urandom_range(8000)), SCALE_W'($urandom_range(1, 1 << 24)));
        run_phase(134, 23, 23, 1'b0);

        if (mismatches == 0)
            $display("load_cell_average_tare_threshold test passed");
        else
            $display("load_cell_average_tare_threshold test failed");
        $finish;
    end

endmodule
